@@ src/etld_pkg.sv @@
// etld_pkg: shared constants for the edge timing log decoder
// no dependencies; used by the channel interfaces and the top level

package etld_pkg;

   localparam int LOG_BYTE_WIDTH = 8;
   localparam int OUT_TIME_WIDTH = 32;
   localparam int HIGH_BITS_WIDTH = 6;
   localparam int OFFSET_WIDTH = 14;

   // top two bits of a lead byte
   typedef enum logic [1:0] {
      LEAD_BASE_LO = 2'b00,
      LEAD_UP      = 2'b01,
      LEAD_DOWN    = 2'b10,
      LEAD_BASE_HI = 2'b11
   } lead_code_type;

   typedef enum logic {
      KIND_DOWN = 1'b0,
      KIND_UP   = 1'b1
   } edge_kind_type;

   localparam logic [OFFSET_WIDTH-1:0] OFFSET_WRAP_FIX = 14'h3fff;

endpackage

@@ src/etld_channels.sv @@
// etld_channels: valid/ready channel interfaces for requests and results
// depends on etld_pkg for payload widths

interface etld_req_if
   import etld_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [LOG_BYTE_WIDTH-1:0] log_byte;

   modport source (output valid, output log_byte, input ready);
   modport sink (input valid, input log_byte, output ready);
endinterface

interface etld_rsp_if
   import etld_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      edge_kind;
   logic [OUT_TIME_WIDTH-1:0] event_time;
   logic [OUT_TIME_WIDTH-1:0] time_since_last;

   modport source (output valid, output edge_kind, output event_time,
                   output time_since_last, input ready);
   modport sink (input valid, input edge_kind, input event_time,
                 input time_since_last, output ready);
endinterface

@@ src/edge_timing_log_decoder.sv @@
// edge_timing_log_decoder: top level, decodes a byte log of timed edges
// depends on etld_pkg and the channel interfaces in etld_channels.sv

// Takes one log byte per request and returns one result per completed edge
// (kind, absolute timestamp, ticks since the previous edge). A byte with top
// bits 10 or 01 opens an edge and holds its high offset bits; the next byte,
// whatever its value, closes it with the low 8 bits. Bytes with top bits 00
// or 11 advance the time base by byte*0x3fff and give no result. Time wraps
// modulo 2^TIME_WIDTH; outputs carry the low 32 bits. Throughput is one byte
// per clock unless stalled: each byte passes an input register, then one
// add/compare/subtract stage into the result register. The request side
// only stalls when a closing byte meets a full result register that is not
// being drained.

module edge_timing_log_decoder
   import etld_pkg::*;
#(
   parameter int TIME_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   etld_req_if.sink   req_bus,
   etld_rsp_if.source rsp_bus
);

   // input register
   logic                      in_valid_ff, in_valid_in;
   logic [LOG_BYTE_WIDTH-1:0] in_byte_ff, in_byte_in;

   // decoder state
   logic                       lead_pending_ff, lead_pending_in;
   logic                       pending_kind_ff, pending_kind_in;
   logic [HIGH_BITS_WIDTH-1:0] pending_high_ff, pending_high_in;
   logic [TIME_WIDTH-1:0]      time_base_ff, time_base_in;
   logic [TIME_WIDTH-1:0]      previous_time_ff, previous_time_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [OUT_TIME_WIDTH-1:0] rsp_time_ff, rsp_time_in;
   logic [OUT_TIME_WIDTH-1:0] rsp_delta_ff, rsp_delta_in;

   logic                  out_free;
   logic                  advance;
   lead_code_type         lead;
   logic [TIME_WIDTH-1:0] stamp;
   logic [TIME_WIDTH-1:0] delta;
   logic [TIME_WIDTH-1:0] base_step;

   // result register can take a new value this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   // held byte moves on unless it closes an edge and the output is blocked
   assign advance  = in_valid_ff && (!lead_pending_ff || out_free);

   assign req_bus.ready = !in_valid_ff || advance;

   assign lead = lead_code_type'(in_byte_ff[LOG_BYTE_WIDTH-1 -: 2]);

   // timestamp of the closing byte and its delta with the 0x3fff correction
   assign stamp = time_base_ff + TIME_WIDTH'({pending_high_ff, in_byte_ff});
   assign delta = (stamp >= previous_time_ff)
                ? stamp - previous_time_ff
                : stamp + TIME_WIDTH'(OFFSET_WRAP_FIX) - previous_time_ff;

   // byte * 0x3fff as (byte << 14) - byte
   assign base_step = TIME_WIDTH'({in_byte_ff, {OFFSET_WIDTH{1'b0}}})
                    - TIME_WIDTH'(in_byte_ff);

   always_comb begin
      in_valid_in      = in_valid_ff;
      in_byte_in       = in_byte_ff;
      lead_pending_in  = lead_pending_ff;
      pending_kind_in  = pending_kind_ff;
      pending_high_in  = pending_high_ff;
      time_base_in     = time_base_ff;
      previous_time_in = previous_time_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_time_in      = rsp_time_ff;
      rsp_delta_in     = rsp_delta_ff;

      // input register
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.log_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // drain of the result register
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         if (lead_pending_ff) begin
            // closing byte: finish the edge
            lead_pending_in  = 1'b0;
            previous_time_in = stamp;
            rsp_valid_in     = 1'b1;
            rsp_kind_in      = pending_kind_ff;
            rsp_time_in      = OUT_TIME_WIDTH'(stamp);
            rsp_delta_in     = OUT_TIME_WIDTH'(delta);
         end else begin
            unique case (lead)
               LEAD_DOWN: begin
                  lead_pending_in = 1'b1;
                  pending_kind_in = KIND_DOWN;
                  pending_high_in = in_byte_ff[HIGH_BITS_WIDTH-1:0];
               end
               LEAD_UP: begin
                  lead_pending_in = 1'b1;
                  pending_kind_in = KIND_UP;
                  pending_high_in = in_byte_ff[HIGH_BITS_WIDTH-1:0];
               end
               default: begin
                  // time base advance byte
                  time_base_in = time_base_ff + base_step;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         lead_pending_ff  <= 1'b0;
         pending_kind_ff  <= KIND_DOWN;
         pending_high_ff  <= '0;
         time_base_ff     <= '0;
         previous_time_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         lead_pending_ff  <= lead_pending_in;
         pending_kind_ff  <= pending_kind_in;
         pending_high_ff  <= pending_high_in;
         time_base_ff     <= time_base_in;
         previous_time_ff <= previous_time_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_delta_ff <= rsp_delta_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.edge_kind       = rsp_kind_ff;
   assign rsp_bus.event_time      = rsp_time_ff;
   assign rsp_bus.time_since_last = rsp_delta_ff;

endmodule

@@ test/edge_timing_log_decoder_tb.sv @@
`timescale 1ns / 1ps
// edge_timing_log_decoder_tb: checks decoded edges against a local model of the byte log
// depends on etld_pkg, etld_channels.sv and edge_timing_log_decoder

module edge_timing_log_decoder_tb;
   import etld_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_BYTES = 220;
   localparam int WRAP_BASE_BYTES = 1100;

   // one decoded edge as it should leave the block
   typedef struct {
      edge_kind_type             kind;
      logic [OUT_TIME_WIDTH-1:0] stamp;
      logic [OUT_TIME_WIDTH-1:0] delta;
   } decoded_edge_type;

   logic clock;
   logic reset = 1'b1;

   etld_req_if req_bus ();
   etld_rsp_if rsp_bus ();

   edge_timing_log_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // model state, mirrors the decoder after each accepted request
   logic                       lead_held;
   edge_kind_type              held_kind;
   logic [HIGH_BITS_WIDTH-1:0] held_high;
   logic [OUT_TIME_WIDTH-1:0]  time_base;
   logic [OUT_TIME_WIDTH-1:0]  last_edge_time;

   decoded_edge_type edges_due[$];
   int               failure_count = 0;
   int               cycle_count = 0;

   // sender pacing
   int burst_left = 0;
   bit idling_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // every input known from time zero
   initial begin
      req_bus.valid = 1'b0;
      req_bus.log_byte = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("edge_timing_log_decoder verification failed");
         $finish;
      end
   end

   task automatic note_failure(input string what);
      failure_count++;
      if (failure_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // ---------------------------------------------------------------
   // model: one accepted log byte, possibly one decoded edge
   // ---------------------------------------------------------------
   task automatic decode_log_byte(input logic [LOG_BYTE_WIDTH-1:0] log_byte);
      decoded_edge_type        edge_out;
      lead_code_type           code;
      logic [OFFSET_WIDTH-1:0] offset;
      code = lead_code_type'(log_byte[7:6]);
      if (lead_held) begin
         // closing byte: any value is taken as the low offset bits
         offset = {held_high, log_byte};
         edge_out.kind = held_kind;
         edge_out.stamp = time_base + OUT_TIME_WIDTH'(offset);
         // going backwards gets the odd 0x3fff correction instead of a true wrap
         if (edge_out.stamp >= last_edge_time)
            edge_out.delta = edge_out.stamp - last_edge_time;
         else
            edge_out.delta = edge_out.stamp + OUT_TIME_WIDTH'(OFFSET_WRAP_FIX)
                             - last_edge_time;
         last_edge_time = edge_out.stamp;
         lead_held = 1'b0;
         edges_due.push_back(edge_out);
      end else begin
         case (code) inside
            LEAD_DOWN, LEAD_UP: begin
               lead_held = 1'b1;
               held_kind = (code == LEAD_UP) ? KIND_UP : KIND_DOWN;
               held_high = log_byte[HIGH_BITS_WIDTH-1:0];
            end
            default: begin
               // time base step, wraps at 32 bits
               time_base = time_base + OUT_TIME_WIDTH'(log_byte)
                           * OUT_TIME_WIDTH'(OFFSET_WRAP_FIX);
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // sender: bursts of requests separated by random gaps
   // ---------------------------------------------------------------
   task automatic send_log_byte(input logic [LOG_BYTE_WIDTH-1:0] log_byte);
      int gap;
      if (burst_left == 0) begin
         gap = idling_on ? $urandom_range(0, 6) : 0;
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.log_byte <= log_byte;
      do @(posedge clock); while (!req_bus.ready);
      decode_log_byte(log_byte);
      burst_left--;
   endtask

   task automatic send_edge(input edge_kind_type kind,
                            input logic [HIGH_BITS_WIDTH-1:0] high_bits,
                            input logic [LOG_BYTE_WIDTH-1:0] low_byte);
      send_log_byte({(kind == KIND_UP) ? LEAD_UP : LEAD_DOWN, high_bits});
      send_log_byte(low_byte);
   endtask

   task automatic send_base_step(input logic [LOG_BYTE_WIDTH-1:0] step_byte);
      // force the top bits to a time base code, keep the rest
      send_log_byte({step_byte[7] ? LEAD_BASE_HI : LEAD_BASE_LO,
                     step_byte[HIGH_BITS_WIDTH-1:0]});
   endtask

   task automatic stop_sending;
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // receiver: ready follows a rotating stall pattern, redrawn now and then
   // ---------------------------------------------------------------
   initial begin : result_drain
      logic [15:0] stall_pattern;
      int          phase;
      stall_pattern = 16'hffff;
      phase = 0;
      forever begin
         @(negedge clock);
         if (phase % 64 == 0) begin
            // roughly a third of the windows never stall
            if ($urandom_range(0, 2) == 0)
               stall_pattern = 16'hffff;
            else
               stall_pattern = 16'($urandom) | 16'h0001;
         end
         rsp_bus.ready <= stall_pattern[phase % 16];
         phase++;
      end
   end

   // ---------------------------------------------------------------
   // result check against the oldest decoded edge still due
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      decoded_edge_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (edges_due.size() == 0) begin
            note_failure($sformatf("unexpected edge kind=%0d time=%h delta=%h",
                                   rsp_bus.edge_kind, rsp_bus.event_time,
                                   rsp_bus.time_since_last));
         end else begin
            due = edges_due.pop_front();
            if (rsp_bus.edge_kind !== due.kind)
               note_failure($sformatf("edge_kind expected %0d got %0d",
                                      due.kind, rsp_bus.edge_kind));
            if (rsp_bus.event_time !== due.stamp)
               note_failure($sformatf("event_time expected %h got %h",
                                      due.stamp, rsp_bus.event_time));
            if (rsp_bus.time_since_last !== due.delta)
               note_failure($sformatf("time_since_last expected %h got %h",
                                      due.delta, rsp_bus.time_since_last));
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // hand-picked bytes: first edge after reset, field extremes, lead-like low
   // bytes, a timestamp that goes backwards, both time base codes
   task automatic test_directed;
      send_edge(KIND_UP, 6'h05, 8'h21);      // delta measured from zero
      send_edge(KIND_DOWN, 6'h3f, 8'hff);    // largest offset
      send_edge(KIND_DOWN, 6'h00, 8'h10);    // earlier than the last edge
      send_edge(KIND_UP, 6'h00, 8'h00);      // smallest offset, backwards again
      send_base_step(8'h00);                 // zero step
      send_base_step(8'h3f);
      send_edge(KIND_UP, 6'h2a, 8'h80);      // low byte looks like a down lead
      send_base_step(8'hc0);
      send_edge(KIND_DOWN, 6'h15, 8'h40);    // low byte looks like an up lead
      send_base_step(8'hff);                 // largest step
      send_edge(KIND_UP, 6'h01, 8'hc0);      // low byte looks like a base step
      send_edge(KIND_DOWN, 6'h3f, 8'h3f);
      send_edge(KIND_UP, 6'h3f, 8'hff);      // same offset twice, zero delta
      send_edge(KIND_UP, 6'h3f, 8'hff);
   endtask

   // push the time base through 2^32 with edges sprinkled in
   task automatic test_time_wrap;
      for (int i = 0; i < WRAP_BASE_BYTES; i++) begin
         send_base_step(8'hff);
         if (i % 40 == 0)
            send_edge(edge_kind_type'($urandom_range(0, 1)),
                      HIGH_BITS_WIDTH'($urandom), LOG_BYTE_WIDTH'($urandom));
      end
   endtask

   // mostly well-formed edge pairs with random content, some base steps and
   // raw noise that can shift the pairing; ends on a lone lead byte
   task automatic test_random_log;
      int sent;
      int pick;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if (sent % 200 == 0)
            idling_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            send_edge(edge_kind_type'($urandom_range(0, 1)),
                      HIGH_BITS_WIDTH'($urandom), LOG_BYTE_WIDTH'($urandom));
            sent += 2;
         end else if (pick < 8) begin
            send_base_step(LOG_BYTE_WIDTH'($urandom));
            sent++;
         end else begin
            send_log_byte(LOG_BYTE_WIDTH'($urandom));
            sent++;
         end
      end
      // a lead byte left hanging must not produce anything
      if (lead_held)
         send_log_byte(LOG_BYTE_WIDTH'($urandom));
      send_log_byte({LEAD_DOWN, HIGH_BITS_WIDTH'($urandom)});
      idling_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      lead_held = 1'b0;
      held_kind = KIND_DOWN;
      held_high = '0;
      time_base = '0;
      last_edge_time = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_time_wrap();
      test_random_log();
      stop_sending();

      // drain, then give the pipeline time to show any stray result
      while (edges_due.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (failure_count == 0) begin
         $display("edge_timing_log_decoder verification clean");
      end else begin
         $display("edge_timing_log_decoder verification failed");
      end
      $finish;
   end

endmodule
